[hw/rtl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types and constants of the Euler angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

	typedef struct packed {
		logic        neg;
		logic [30:0] mag;
	} sm_t;

	typedef struct packed {
		sm_t s;
		sm_t c;
	} sc_t;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// Pi in Q2.30 split as 45 * PI_DIV45 + PI_REM45.
	localparam logic [26:0] PI_DIV45 = 27'd74961320;
	localparam logic [4:0]  PI_REM45 = 5'd26;
	localparam logic [10:0] RECIP45  = 11'd1457;
	localparam int          RECIP45_SH = 16;

	localparam logic [30:0] SIN_RECIP [5] = '{
		31'd1249445032, 31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766
	};
	localparam int SIN_SHIFT [5] = '{37, 37, 36, 35, 33};

	localparam logic [30:0] COS_RECIP [6] = '{
		31'd2082408386, 31'd1527099484, 31'd1227133514, 31'd1145324613,
		31'd1431655766, 31'd1073741824
	};
	localparam int COS_SHIFT [6] = '{38, 37, 36, 35, 34, 31};

	localparam int SC_LAT = 19;

endpackage

[hw/rtl/e2q_sincos.sv]
// ----------------------------------------------------------------------------
// e2q_sincos
// Pipelined sine and cosine of half an angle given in fixed-point degrees.
// ----------------------------------------------------------------------------
module e2q_sincos #(
	parameter int ANGLE_FRAC_BITS = 7
) (
	input  logic               clk,
	input  logic signed [16:0] angle,
	output e2q_pkg::sc_t       sc
);

	localparam int    K    = ANGLE_FRAC_BITS + 3;
	localparam longint QUAD = longint'(45) << (ANGLE_FRAC_BITS + 2);
	localparam longint FULL = 4 * QUAD;
	localparam longint OFS  = FULL * ((65536 + FULL - 1) / FULL);
	localparam longint UMAX = OFS + 65535;
	localparam int    UW   = $clog2(UMAX + 1);
	localparam int    NQ   = $clog2(UMAX / QUAD + 1);
	localparam int    CW   = UW + NQ;
	localparam int    RW   = $clog2(QUAD);
	localparam int    PW   = RW + 27;
	localparam int    EW   = K + 9;

	logic [RW-1:0] r_s1, rf_s2, rf_s3;
	logic [1:0]    q_s1, q_s2, q_s3, q_s4, q_s5, q_s6;
	logic          fold_s2, fold_s3, fold_s4, fold_s5, fold_s6;
	logic [PW-1:0] prod_s3;
	logic [29:0]   a_s4, x_s5, x_s6, x2_s6;
	logic [EW-1:0] e_s4;

	logic [RW-1:0] r_next;
	logic [1:0]    q_next;

	always_comb begin
		logic signed [31:0] a_ext;
		logic [31:0]        u32;
		logic [CW-1:0]      rem;
		logic [NQ-1:0]      quo;
		a_ext = 32'(angle);
		u32   = unsigned'(a_ext + 32'(OFS));
		rem   = CW'(u32);
		quo   = '0;
		for (int k = NQ - 1; k >= 0; k--) begin
			if (rem >= (CW'(QUAD) << k)) begin
				rem    = rem - (CW'(QUAD) << k);
				quo[k] = 1'b1;
			end
		end
		r_next = rem[RW-1:0];
		q_next = quo[1:0];
	end

	always_ff @(posedge clk) begin
		r_s1 <= r_next;
		q_s1 <= q_next;
	end

	always_ff @(posedge clk) begin
		fold_s2 <= ({1'b0, r_s1, 1'b0} > (RW + 2)'(QUAD));
		rf_s2   <= ({r_s1, 1'b0} > (RW + 1)'(QUAD)) ? RW'(QUAD) - r_s1 : r_s1;
		q_s2    <= q_s1;
	end

	always_ff @(posedge clk) begin
		prod_s3 <= PW'(rf_s2) * PW'(e2q_pkg::PI_DIV45);
		rf_s3   <= rf_s2;
		fold_s3 <= fold_s2;
		q_s3    <= q_s2;
	end

	always_ff @(posedge clk) begin
		a_s4    <= prod_s3[K+29:K];
		e_s4    <= EW'(prod_s3[K-1:0]) * EW'(45) + EW'(rf_s3) * EW'(e2q_pkg::PI_REM45)
			+ (EW'(45) << (K - 1));
		fold_s4 <= fold_s3;
		q_s4    <= q_s3;
	end

	logic [19:0] corr_prod;
	assign corr_prod = 20'(e_s4[EW-1:K]) * 20'(e2q_pkg::RECIP45);

	always_ff @(posedge clk) begin
		x_s5    <= a_s4 + 30'(corr_prod[19:e2q_pkg::RECIP45_SH]);
		fold_s5 <= fold_s4;
		q_s5    <= q_s4;
	end

	logic [59:0] sq_prod;
	assign sq_prod = 60'(x_s5) * 60'(x_s5);

	always_ff @(posedge clk) begin
		x2_s6   <= sq_prod[59:30];
		x_s6    <= x_s5;
		fold_s6 <= fold_s5;
		q_s6    <= q_s5;
	end

	logic [29:0] x_p [10];
	logic [29:0] x2_p [10];
	logic        fold_p [12];
	logic [1:0]  q_p [12];

	always_ff @(posedge clk) begin
		x_p[0]    <= x_s6;
		x2_p[0]   <= x2_s6;
		fold_p[0] <= fold_s6;
		q_p[0]    <= q_s6;
		for (int i = 1; i < 10; i++) begin
			x_p[i]  <= x_p[i-1];
			x2_p[i] <= x2_p[i-1];
		end
		for (int i = 1; i < 12; i++) begin
			fold_p[i] <= fold_p[i-1];
			q_p[i]    <= q_p[i-1];
		end
	end

	logic [29:0] cv_s [6];
	logic [29:0] sv_s [6];
	logic [30:0] ct_s [6];
	logic [30:0] st_s [6];

	for (genvar j = 0; j < 6; j++) begin : g_step
		logic [29:0] x2_in;
		logic [30:0] ct_in, st_in;
		logic [60:0] cprod, sprod, cq;

		if (j == 0) begin : g_first
			assign x2_in = x2_s6;
			assign ct_in = e2q_pkg::ONE_Q30;
			assign st_in = e2q_pkg::ONE_Q30;
		end else begin : g_next
			assign x2_in = x2_p[2*j-1];
			assign ct_in = ct_s[j-1];
			assign st_in = st_s[j-1];
		end

		assign cprod = 61'(x2_in) * 61'(ct_in);
		assign cq    = 61'(cv_s[j]) * 61'(e2q_pkg::COS_RECIP[j]);

		always_ff @(posedge clk) begin
			cv_s[j] <= cprod[59:30];
			ct_s[j] <= e2q_pkg::ONE_Q30 - 31'(cq >> e2q_pkg::COS_SHIFT[j]);
		end

		if (j < 5) begin : g_sin_step
			logic [60:0] sq;
			assign sprod = 61'(x2_in) * 61'(st_in);
			assign sq    = 61'(sv_s[j]) * 61'(e2q_pkg::SIN_RECIP[j]);
			always_ff @(posedge clk) begin
				sv_s[j] <= sprod[59:30];
				st_s[j] <= e2q_pkg::ONE_Q30 - 31'(sq >> e2q_pkg::SIN_SHIFT[j]);
			end
		end else begin : g_sin_last
			assign sprod = 61'(x_p[9]) * 61'(st_in);
			always_ff @(posedge clk) begin
				sv_s[j] <= sprod[59:30];
				st_s[j] <= 31'(sv_s[j]);
			end
		end
	end

	e2q_pkg::sc_t sc_s19;

	always_ff @(posedge clk) begin
		logic [30:0] ps, pc;
		ps = fold_p[11] ? ct_s[5] : st_s[5];
		pc = fold_p[11] ? st_s[5] : ct_s[5];
		case (q_p[11])
			2'd0: sc_s19 <= '{s: '{neg: 1'b0, mag: ps}, c: '{neg: 1'b0, mag: pc}};
			2'd1: sc_s19 <= '{s: '{neg: 1'b0, mag: pc}, c: '{neg: 1'b1, mag: ps}};
			2'd2: sc_s19 <= '{s: '{neg: 1'b1, mag: ps}, c: '{neg: 1'b1, mag: pc}};
			default: sc_s19 <= '{s: '{neg: 1'b1, mag: pc}, c: '{neg: 1'b0, mag: ps}};
		endcase
	end

	assign sc = sc_s19;

endmodule

[hw/rtl/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Converts roll, yaw and pitch in fixed-point degrees to a unit quaternion.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and busy is always low. Each
// item comes out on the quat ports with done high once it has passed the
// per-angle sine and cosine pipelines, with their six nested series steps,
// and the registered stages for the products, sums and output rounding.
// Results are shown for one cycle only and cannot be held off, so the
// receiver must take every one of them.
module euler_to_quaternion #(
	parameter int ANGLE_FRAC_BITS = 7,
	parameter int QUAT_FRAC_BITS  = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [16:0]             roll_deg,
	input  logic signed [16:0]             yaw_deg,
	input  logic signed [16:0]             pitch_deg,
	output logic                           done,
	output logic signed [QUAT_FRAC_BITS+1:0] quat_x,
	output logic signed [QUAT_FRAC_BITS+1:0] quat_y,
	output logic signed [QUAT_FRAC_BITS+1:0] quat_z,
	output logic signed [QUAT_FRAC_BITS+1:0] quat_w
);

	localparam int OW   = QUAT_FRAC_BITS + 2;
	localparam int LAT  = e2q_pkg::SC_LAT + 4;
	localparam int SH   = 30 - QUAT_FRAC_BITS;
	localparam int QLIM = 1 << QUAT_FRAC_BITS;
	localparam logic [32:0] RND = 33'((64'd1 << SH) >> 1);
	localparam logic [32:0] LIM = 33'(1) << QUAT_FRAC_BITS;

	function automatic e2q_pkg::sm_t mulq(e2q_pkg::sm_t a, e2q_pkg::sm_t b);
		logic [61:0]  p;
		e2q_pkg::sm_t r;
		p     = 62'(a.mag) * 62'(b.mag) + (62'(1) << 29);
		r.neg = a.neg ^ b.neg;
		r.mag = p[60:30];
		return r;
	endfunction

	function automatic logic signed [32:0] to_sv(e2q_pkg::sm_t a);
		logic signed [32:0] m;
		m = signed'({2'b00, a.mag});
		return a.neg ? -m : m;
	endfunction

	function automatic logic [OW-1:0] to_out(logic signed [32:0] v);
		logic [32:0] mag;
		mag = v[32] ? unsigned'(-v) : unsigned'(v);
		mag = (mag + RND) >> SH;
		if (mag > LIM) begin
			mag = LIM;
		end
		return v[32] ? OW'(33'd0 - mag) : OW'(mag);
	endfunction

	e2q_pkg::sc_t sc1, sc2, sc3;

	e2q_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
		.clk(clk), .angle(roll_deg), .sc(sc1)
	);
	e2q_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_yaw (
		.clk(clk), .angle(yaw_deg), .sc(sc2)
	);
	e2q_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
		.clk(clk), .angle(pitch_deg), .sc(sc3)
	);

	assign busy = 1'b0;

	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done = vld_q[LAT-1];

	e2q_pkg::sm_t p_sc_s1, p_cs_s1, p_cc_s1, p_ss_s1, s3_s1, c3_s1;

	always_ff @(posedge clk) begin
		p_sc_s1 <= mulq(sc1.s, sc2.c);
		p_cs_s1 <= mulq(sc1.c, sc2.s);
		p_cc_s1 <= mulq(sc1.c, sc2.c);
		p_ss_s1 <= mulq(sc1.s, sc2.s);
		s3_s1   <= sc3.s;
		c3_s1   <= sc3.c;
	end

	e2q_pkg::sm_t xa_s2, xb_s2, ya_s2, yb_s2, za_s2, zb_s2, wa_s2, wb_s2;

	always_ff @(posedge clk) begin
		xa_s2 <= mulq(p_sc_s1, c3_s1);
		xb_s2 <= mulq(p_cs_s1, s3_s1);
		ya_s2 <= mulq(p_cs_s1, c3_s1);
		yb_s2 <= mulq(p_sc_s1, s3_s1);
		za_s2 <= mulq(p_cc_s1, s3_s1);
		zb_s2 <= mulq(p_ss_s1, c3_s1);
		wa_s2 <= mulq(p_cc_s1, c3_s1);
		wb_s2 <= mulq(p_ss_s1, s3_s1);
	end

	logic signed [32:0] x_s3, y_s3, z_s3, w_s3;

	always_ff @(posedge clk) begin
		x_s3 <= to_sv(xa_s2) + to_sv(xb_s2);
		y_s3 <= to_sv(ya_s2) + to_sv(yb_s2);
		z_s3 <= to_sv(za_s2) - to_sv(zb_s2);
		w_s3 <= to_sv(wa_s2) - to_sv(wb_s2);
	end

	logic [OW-1:0] x_s4, y_s4, z_s4, w_s4;

	always_ff @(posedge clk) begin
		x_s4 <= to_out(x_s3);
		y_s4 <= to_out(y_s3);
		z_s4 <= to_out(z_s3);
		w_s4 <= to_out(w_s3);
	end

	assign quat_x = signed'(x_s4);
	assign quat_y = signed'(y_s4);
	assign quat_z = signed'(z_s4);
	assign quat_w = signed'(w_s4);

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("item taken without a result after the pipeline latency");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching item");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (quat_w <= QLIM && quat_w >= -QLIM && quat_x <= QLIM && quat_x >= -QLIM))
		else $error("quaternion component beyond saturation limit");

endmodule
